// ===== rtl/core/sscan_pkg.sv =====
// Shared types, constants and the character encoder for the seven-segment
// scan controller. No dependencies; imported by sscan_cell and the top level.
package sscan_pkg;

    localparam int NUM_DIGITS_DEF = 4;
    localparam int MAX_LEVEL_DEF  = 4;

    localparam int SEG_W = 8;
    localparam int CMD_W = 3;
    localparam int POS_W = 3;
    localparam int CHR_W = 8;
    localparam int AMT_W = 8;
    localparam int LVL_W = 3;
    localparam int SEL_W = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ONE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHIFT_FILL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SHIFT_INSERT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SCAN         = 3'd5;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    typedef logic [SEG_W-1:0] t_pattern;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_CLEAR,
        CELL_FROM_LO,
        CELL_FROM_HI
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_pattern data;
    } t_cell_ctrl;

    function automatic t_pattern encode_char(input logic [CHR_W-1:0] c);
        t_pattern p;
        unique case (c)
            8'h30: p = 8'h3F; // '0'
            8'h31: p = 8'h06;
            8'h32: p = 8'h5B;
            8'h33: p = 8'h4F;
            8'h34: p = 8'h66;
            8'h35: p = 8'h6D;
            8'h36: p = 8'h7D;
            8'h37: p = 8'h07;
            8'h38: p = 8'h7F;
            8'h39: p = 8'h6F;
            8'h41: p = 8'h77; // 'A'
            8'h42: p = 8'h7C;
            8'h43: p = 8'h39;
            8'h44: p = 8'h5E;
            8'h45: p = 8'h79;
            8'h46: p = 8'h71;
            8'h47: p = 8'h6F;
            8'h48: p = 8'h76;
            8'h49: p = 8'h06;
            8'h4A: p = 8'h0E;
            8'h4B: p = 8'h70;
            8'h4C: p = 8'h38;
            8'h4D: p = 8'h15;
            8'h4E: p = 8'h37;
            8'h4F: p = 8'h3F;
            8'h50: p = 8'h73;
            8'h51: p = 8'h67;
            8'h52: p = 8'h31;
            8'h53: p = 8'h6D;
            8'h54: p = 8'h78;
            8'h55: p = 8'h3E;
            8'h56: p = 8'h1C;
            8'h57: p = 8'h2A;
            8'h58: p = 8'h46;
            8'h59: p = 8'h6E;
            8'h5A: p = 8'h5B; // 'Z'
            8'h2D: p = 8'h40; // '-'
            8'h5F: p = 8'h08; // '_'
            default: p = SEG_BLANK;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/sscan_cell.sv =====
// One digit cell of the display store: holds one segment pattern and can
// take its neighbour's pattern each cycle. Depends on sscan_pkg.
module sscan_cell
    import sscan_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_pattern   i_from_lo,
    input  t_pattern   i_from_hi,
    output t_pattern   o_pattern
);

    t_pattern r_pattern;
    t_pattern n_pattern;

    always_comb begin
        unique case (i_ctrl.op)
            CELL_LOAD:    n_pattern = i_ctrl.data;
            CELL_CLEAR:   n_pattern = SEG_BLANK;
            CELL_FROM_LO: n_pattern = i_from_lo;
            CELL_FROM_HI: n_pattern = i_from_hi;
            default:      n_pattern = r_pattern;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= SEG_BLANK;
        end else begin
            r_pattern <= n_pattern;
        end
    end

    assign o_pattern = r_pattern;

endmodule

// ===== rtl/core/seven_segment_scan_controller.sv =====
// Top level of the multiplexed seven-segment scan controller: a chain of
// sscan_cell digit cells plus scan, duty and shift-step control. Uses sscan_pkg.
//
// A command is taken when start is high and busy is low. Every command is done
// when taken, except a shift with blank fill by k places (0 < k < NUM_DIGITS),
// which moves the cell chain one place per cycle, k places in all, with busy
// high after the request until the last place is moved. A scan tick gives one
// result on the cycle after its request: o_strobe is high for that single
// cycle together with o_segments and o_select_lines, and must be captured
// then, as there is no way to hold it. The brightness register may be written
// at any cycle while no command is in progress.
module seven_segment_scan_controller
    import sscan_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF,
    parameter int MAX_LEVEL  = MAX_LEVEL_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] i_command,
    input  logic [POS_W-1:0] i_position,
    input  logic [CHR_W-1:0] i_character,
    input  logic             i_direction,
    input  logic [AMT_W-1:0] i_shift_amount,
    input  logic             i_cfg_we,
    input  logic [LVL_W-1:0] i_cfg_data,
    output logic             o_strobe,
    output logic [SEG_W-1:0] o_segments,
    output logic [SEL_W-1:0] o_select_lines
);

    localparam int IDX_W  = $clog2(NUM_DIGITS);
    localparam int DUTY_W = $clog2(MAX_LEVEL + 1);
    localparam int CMP_W  = 5;

    logic                 acc;
    logic                 step_now;
    logic                 step_dir;
    logic                 fill_in_range;
    logic                 do_insert;
    t_pattern             ins_pattern;
    t_pattern             end_feed;
    t_pattern             cell_q [NUM_DIGITS];
    t_cell_ctrl           cell_ctrl [NUM_DIGITS];

    logic [IDX_W-1:0]     r_steps;
    logic [IDX_W-1:0]     n_steps;
    logic                 r_dir;
    logic [IDX_W-1:0]     r_scan;
    logic [DUTY_W-1:0]    r_duty;
    logic [LVL_W-1:0]     r_bright;
    logic                 r_strobe;
    t_pattern             r_seg;
    logic [SEL_W-1:0]     r_sel;

    assign busy = (r_steps != '0);
    assign acc  = start && !busy;

    assign ins_pattern   = encode_char(i_character);
    assign fill_in_range = (i_shift_amount != '0) &&
                           (i_shift_amount < AMT_W'(NUM_DIGITS));
    assign do_insert     = acc && (i_command == CMD_SHIFT_INSERT);
    assign step_now      = busy || (acc && (i_command == CMD_SHIFT_FILL) && fill_in_range);
    assign step_dir      = busy ? r_dir : i_direction;
    // The vacated end gets the new character on insert, blank on a fill step.
    assign end_feed      = do_insert ? ins_pattern : SEG_BLANK;

    always_comb begin
        n_steps = r_steps;
        if (busy) begin
            n_steps = r_steps - IDX_W'(1);
        end else if (step_now) begin
            n_steps = IDX_W'(i_shift_amount - AMT_W'(1));
        end
    end

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        t_pattern from_lo;
        t_pattern from_hi;

        if (g == 0) begin : g_lo_end
            assign from_lo = end_feed;
        end else begin : g_lo_mid
            assign from_lo = cell_q[g-1];
        end
        if (g == NUM_DIGITS - 1) begin : g_hi_end
            assign from_hi = end_feed;
        end else begin : g_hi_mid
            assign from_hi = cell_q[g+1];
        end

        always_comb begin
            cell_ctrl[g].op   = CELL_HOLD;
            cell_ctrl[g].data = ins_pattern;
            if (step_now || do_insert) begin
                cell_ctrl[g].op = step_dir ? CELL_FROM_LO : CELL_FROM_HI;
            end else if (acc) begin
                unique case (i_command)
                    CMD_WRITE: begin
                        if (i_position == POS_W'(g)) cell_ctrl[g].op = CELL_LOAD;
                    end
                    CMD_CLEAR_ONE: begin
                        if (i_position == POS_W'(g)) cell_ctrl[g].op = CELL_CLEAR;
                    end
                    CMD_CLEAR_ALL: cell_ctrl[g].op = CELL_CLEAR;
                    CMD_SHIFT_FILL: begin
                        // zero amount is a no-op; anything too large blanks all
                        if (i_shift_amount != '0) cell_ctrl[g].op = CELL_CLEAR;
                    end
                    default: cell_ctrl[g].op = CELL_HOLD;
                endcase
            end
        end

        sscan_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (cell_ctrl[g]),
            .i_from_lo (from_lo),
            .i_from_hi (from_hi),
            .o_pattern (cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps  <= '0;
            r_scan   <= '0;
            r_duty   <= '0;
            r_bright <= LVL_W'(1);
            r_strobe <= 1'b0;
        end else begin
            r_steps  <= n_steps;
            r_strobe <= acc && (i_command == CMD_SCAN);
            if (i_cfg_we) begin
                if (CMP_W'(i_cfg_data) > CMP_W'(MAX_LEVEL)) begin
                    r_bright <= LVL_W'(MAX_LEVEL);
                end else begin
                    r_bright <= i_cfg_data;
                end
            end
            if (acc && (i_command == CMD_SCAN)) begin
                if (r_scan == IDX_W'(NUM_DIGITS - 1)) begin
                    r_scan <= '0;
                    // duty counter moves once per full sweep
                    if (r_duty == DUTY_W'(MAX_LEVEL)) begin
                        r_duty <= '0;
                    end else begin
                        r_duty <= r_duty + DUTY_W'(1);
                    end
                end else begin
                    r_scan <= r_scan + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!busy) begin
            r_dir <= i_direction;
        end
        if (acc && (i_command == CMD_SCAN)) begin
            r_seg <= (CMP_W'(r_duty) < CMP_W'(r_bright)) ? cell_q[r_scan] : SEG_BLANK;
            r_sel <= SEL_W'(2'd3 - SEL_W'(r_scan));
        end
    end

    assign o_strobe       = r_strobe;
    assign o_segments     = r_seg;
    assign o_select_lines = r_sel;

    a_strobe_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_command == CMD_SCAN)) |=> o_strobe)
        else $error("scan request gave no result");

    a_no_spurious_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(acc && (i_command == CMD_SCAN)) |=> !o_strobe)
        else $error("result without scan request");

    a_busy_only_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(acc && (i_command == CMD_SHIFT_FILL)))
        else $error("busy raised by a command other than shift fill");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan <= IDX_W'(NUM_DIGITS - 1)) && (r_duty <= DUTY_W'(MAX_LEVEL)))
        else $error("scan index or duty counter out of range");

endmodule
